>>> hw/rtl/srf_pkg.sv
package srf_pkg;

    // storage geometry
    localparam int DEPTH      = 8;
    localparam int DATA_WIDTH = 32;
    localparam int OCC_W      = $clog2(DEPTH + 1);
    localparam int PTR_W      = $clog2(DEPTH);

    // command codes
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_POP  = 3'd1;
    localparam logic [2:0] OP_PEEK = 3'd2;
    localparam logic [2:0] OP_AT   = 3'd3;
    localparam logic [2:0] OP_FIND = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
        logic [2:0]         index;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] read_value;
        logic [2:0]         found_index;
        logic [3:0]         fill_level;
    } t_result;

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    // command word into stored width, sign extended or cut
    function automatic t_word to_word(input logic signed [31:0] v);
        return DATA_WIDTH'(v);
    endfunction

    // stored word back to 32 bits, sign extended from the stored width
    function automatic logic signed [31:0] from_word(input t_word w);
        return 32'($signed(w));
    endfunction

endpackage

>>> hw/rtl/searchable_ring_fifo.sv
// searchable ring fifo: a queue of signed words that can also be read at a
// position and searched for a word.
// command channel: i_cmd is taken at a rising edge where i_start is high and
// o_busy is low; one command per transfer, ops push, pop, peek, indexed read
// and find first.
// result channel: exactly one result per command, shown on o_result for a
// single cycle while o_done is high; there is no back pressure, the receiver
// must take it in that cycle.
// latency: push, pop, peek, unused op codes and failing commands give their
// result in the cycle after the transfer, so one such command can follow
// every cycle.
// indexed read and find rotate the row of DEPTH storage cells one full turn,
// one cell per cycle, and watch the head cell; o_busy is high while the ring
// turns, and the result is registered on the step that completes the turn.
// a command may be issued in the same cycle its predecessor's result shows.
// reset (synchronous, active low) empties the queue and drops any command in
// flight; stored words are not cleared and are never read before written.
module searchable_ring_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  srf_pkg::t_cmd    i_cmd,
    output logic             o_busy,
    output logic             o_done,
    output srf_pkg::t_result o_result
);
    import srf_pkg::*;

    t_cell_ctl cell_ctl [DEPTH];
    t_word     cell_word [DEPTH];
    t_word     din;

    // sequencer
    srf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .i_head   (cell_word[0]),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result),
        .o_ctl    (cell_ctl),
        .o_din    (din)
    );

    // ring of cells, each taking its right neighbor's word on a shift
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        srf_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (cell_ctl[k]),
            .i_din  (din),
            .i_next (cell_word[(k + 1) % DEPTH]),
            .o_word (cell_word[k])
        );
    end

endmodule

>>> hw/rtl/srf_cell.sv
module srf_cell (
    input  logic              i_clk,
    input  srf_pkg::t_cell_ctl i_ctl,
    input  srf_pkg::t_word    i_din,
    input  srf_pkg::t_word    i_next,
    output srf_pkg::t_word    o_word
);
    import srf_pkg::*;

    t_word r_word;

    // take the neighbor's word on a shift, the pushed word on a load
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_word <= i_next;
        end else if (i_ctl.load) begin
            r_word <= i_din;
        end
    end

    assign o_word = r_word;

endmodule

>>> hw/rtl/srf_ctrl.sv
module srf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  srf_pkg::t_cmd      i_cmd,
    input  srf_pkg::t_word     i_head,
    output logic               o_busy,
    output logic               o_done,
    output srf_pkg::t_result   o_result,
    output srf_pkg::t_cell_ctl o_ctl [srf_pkg::DEPTH],
    output srf_pkg::t_word     o_din
);
    import srf_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic               r_state, n_state;
    logic [OCC_W-1:0]   r_occ, n_occ;
    logic [PTR_W-1:0]   r_step, n_step;
    logic               r_find, n_find;
    logic               r_hit, n_hit;
    logic [2:0]         r_fidx, n_fidx;
    logic [2:0]         r_idx, n_idx;
    logic signed [31:0] r_rd, n_rd;
    t_word              r_val, n_val;
    logic               r_done, n_done;
    t_result            r_result, n_result;
    logic               shift;
    logic               push;
    logic               accept;

    assign accept = i_start && (r_state == S_IDLE);

    // command decode and scan sequencing
    always_comb begin
        n_state  = r_state;
        n_occ    = r_occ;
        n_step   = r_step;
        n_find   = r_find;
        n_hit    = r_hit;
        n_fidx   = r_fidx;
        n_idx    = r_idx;
        n_rd     = r_rd;
        n_val    = r_val;
        n_done   = 1'b0;
        n_result = r_result;
        shift    = 1'b0;
        push     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_result = '0;
                    n_done   = 1'b1;
                    unique case (i_cmd.op)
                        OP_PUSH: begin
                            if (r_occ == OCC_W'(DEPTH)) begin
                                n_result.status = ST_FULL;
                            end else begin
                                push  = 1'b1;
                                n_occ = r_occ + 1'b1;
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (r_occ == '0) begin
                                n_result.status = ST_EMPTY;
                            end else begin
                                n_result.read_value = from_word(i_head);
                                if (i_cmd.op == OP_POP) begin
                                    shift = 1'b1;
                                    n_occ = r_occ - 1'b1;
                                end
                            end
                        end
                        OP_AT: begin
                            if (32'(i_cmd.index) >= 32'(r_occ)) begin
                                n_result.status = ST_RANGE;
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_SCAN;
                                n_step  = '0;
                                n_find  = 1'b0;
                                n_idx   = i_cmd.index;
                                n_rd    = '0;
                            end
                        end
                        OP_FIND: begin
                            if (r_occ == '0) begin
                                n_result.status = ST_NOTFOUND;
                            end else begin
                                n_done  = 1'b0;
                                n_state = S_SCAN;
                                n_step  = '0;
                                n_find  = 1'b1;
                                n_hit   = 1'b0;
                                n_fidx  = '0;
                                n_val   = to_word(i_cmd.value);
                            end
                        end
                        default: begin
                            n_result.status = ST_OK;
                        end
                    endcase
                    n_result.fill_level = 4'(n_occ);
                end
            end
            S_SCAN: begin
                // rotate the ring one cell; the head holds position r_step
                shift  = 1'b1;
                n_step = r_step + 1'b1;
                if (!r_find && (32'(r_step) == 32'(r_idx))) begin
                    n_rd = from_word(i_head);
                end
                if (r_find && !r_hit && (32'(r_step) < 32'(r_occ)) && (i_head == r_val)) begin
                    n_hit  = 1'b1;
                    n_fidx = 3'(r_step);
                end
                // a full turn restores the order
                if (r_step == PTR_W'(DEPTH - 1)) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_result = '0;
                    if (r_find) begin
                        n_result.status      = n_hit ? ST_OK : ST_NOTFOUND;
                        n_result.found_index = n_hit ? n_fidx : 3'd0;
                    end else begin
                        n_result.status     = ST_OK;
                        n_result.read_value = n_rd;
                    end
                    n_result.fill_level = 4'(r_occ);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_step  <= '0;
            r_find  <= 1'b0;
            r_hit   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_step  <= n_step;
            r_find  <= n_find;
            r_hit   <= n_hit;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_fidx   <= n_fidx;
        r_idx    <= n_idx;
        r_rd     <= n_rd;
        r_val    <= n_val;
        r_result <= n_result;
    end

    // per-cell controls: push lands in the first free cell
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            o_ctl[k].shift = shift;
            o_ctl[k].load  = push && (r_occ == OCC_W'(k));
        end
    end

    assign o_din    = to_word(i_cmd.value);
    assign o_busy   = (r_state == S_SCAN);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> hw/rtl/srf_checker.sv
module srf_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_start,
    input srf_pkg::t_cmd    i_cmd,
    input logic             o_busy,
    input logic             o_done,
    input srf_pkg::t_result o_result
);
    import srf_pkg::*;

    logic xfer;
    assign xfer = i_rst_n && i_start && !o_busy;

    // short commands answer in the next cycle
    a_short_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && (i_cmd.op == OP_PUSH || i_cmd.op == OP_POP || i_cmd.op == OP_PEEK))
        |=> (o_done && !o_busy))
        else $error("short command gave no result in the next cycle");

    // scanning commands either answer at once or start a scan
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && (i_cmd.op == OP_AT || i_cmd.op == OP_FIND)) |=> (o_busy || o_done))
        else $error("read or find transfer neither answered nor scanning");

    // occupancy stays within the depth
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_result.fill_level) <= DEPTH))
        else $error("fill level beyond depth");

    // full only when every cell is taken
    a_full_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_FULL) |-> (32'(o_result.fill_level) == DEPTH))
        else $error("full status with free cells");

    // empty only when nothing is stored
    a_empty_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_EMPTY) |-> (o_result.fill_level == 4'd0))
        else $error("empty status with stored words");

endmodule

bind searchable_ring_fifo srf_checker u_srf_checker (.*);

>>> bench/testbench.sv
module testbench;
    import srf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_start;
    t_cmd    i_cmd;
    logic    o_busy;
    logic    o_done;
    t_result o_result;

    // shadow copy of the queue contents and pointers
    t_word   fifo_words [DEPTH];
    int      fifo_wr    = 0;
    int      fifo_rd    = 0;
    int      fifo_count = 0;

    t_result pending_responses [$];
    int      error_count  = 0;
    int      stall_cycles = 0;
    bit      sender_idles = 1'b1;

    searchable_ring_fifo i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // work out the response of one accepted command and update the shadow queue
    function automatic void predict_fifo_response(input t_cmd c);
        t_result                      r;
        t_word                        key;
        logic signed [DATA_WIDTH-1:0] stored;
        int                           i;
        bit                           hit;
        r   = '0;
        key = c.value;
        hit = 1'b0;
        case (c.op)
            OP_PUSH: begin
                if (fifo_count == DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    fifo_words[fifo_wr] = key;
                    fifo_wr    = (fifo_wr + 1) % DEPTH;
                    fifo_count = fifo_count + 1;
                end
            end
            OP_POP, OP_PEEK: begin
                if (fifo_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    stored       = fifo_words[fifo_rd];
                    r.read_value = stored;
                    if (c.op == OP_POP) begin
                        fifo_rd    = (fifo_rd + 1) % DEPTH;
                        fifo_count = fifo_count - 1;
                    end
                end
            end
            OP_AT: begin
                if (c.index >= fifo_count) begin
                    r.status = ST_RANGE;
                end else begin
                    stored       = fifo_words[(fifo_rd + c.index) % DEPTH];
                    r.read_value = stored;
                end
            end
            OP_FIND: begin
                r.status = ST_NOTFOUND;
                for (i = 0; i < fifo_count && !hit; i++) begin
                    if (fifo_words[(fifo_rd + i) % DEPTH] == key) begin
                        hit           = 1'b1;
                        r.status      = ST_OK;
                        r.found_index = 3'(i);
                    end
                end
            end
            // unused op codes leave everything alone
            default: ;
        endcase
        r.fill_level = 4'(fifo_count);
        pending_responses.push_back(r);
    endfunction

    // one command transfer, with random idle cycles ahead of it while sender_idles is set
    task automatic send_cmd(input logic [2:0] op, input logic signed [31:0] value,
                            input logic [2:0] index);
        t_cmd c;
        int   gap;
        c.op    = op;
        c.value = value;
        c.index = index;
        gap = 0;
        if (sender_idles) begin
            while ($urandom_range(99) < 27) gap++;
        end
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= c;
        do @(posedge i_clk); while (o_busy);
        predict_fifo_response(c);
    endtask

    // hold off until every outstanding response has been seen
    task automatic wait_until_drained();
        i_start <= 1'b0;
        do @(negedge i_clk); while (pending_responses.size() != 0);
        @(posedge i_clk);
    endtask

    // extremes, small values and negatives so that duplicates show up often
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            4, 5:    return 32'($urandom_range(5));
            6:       return -32'($urandom_range(4));
            default: return $urandom;
        endcase
    endfunction

    // mostly a word that is in the queue, so that find hits
    function automatic logic signed [31:0] pick_search_word();
        if (fifo_count > 0 && $urandom_range(3) != 0)
            return fifo_words[(fifo_rd + $urandom_range(fifo_count - 1)) % DEPTH];
        return pick_word();
    endfunction

    // mostly a position inside the occupancy
    function automatic logic [2:0] pick_index();
        if (fifo_count > 0 && $urandom_range(9) < 7)
            return 3'($urandom_range(fifo_count - 1));
        return 3'($urandom_range(7));
    endfunction

    // empty, full, extreme words, first and last position, unused op codes
    task automatic run_directed_corners();
        int k;
        send_cmd(OP_POP, 32'sh7fff_ffff, 3'd0);
        send_cmd(OP_PEEK, 32'sh8000_0000, 3'd7);
        send_cmd(OP_AT, -32'sd1, 3'd0);
        send_cmd(OP_AT, 32'sd0, 3'd7);
        send_cmd(OP_FIND, 32'sd0, 3'd0);
        for (k = 1; k <= 3; k++) send_cmd(OP_FIND + 3'(k), -32'sd1, 3'd7);
        send_cmd(OP_PUSH, 32'sh8000_0000, 3'd0);
        send_cmd(OP_PUSH, 32'sh7fff_ffff, 3'd7);
        send_cmd(OP_PUSH, 32'sd0, 3'd0);
        send_cmd(OP_PUSH, -32'sd1, 3'd0);
        send_cmd(OP_PUSH, 32'sd1, 3'd0);
        send_cmd(OP_PUSH, 32'shaaaa_aaaa, 3'd0);
        send_cmd(OP_PUSH, 32'sh5555_5555, 3'd0);
        send_cmd(OP_PUSH, 32'sh1234_5678, 3'd0);
        // queue is full now
        send_cmd(OP_PUSH, 32'sd99, 3'd0);
        send_cmd(OP_AT, 32'sd0, 3'd7);
        send_cmd(OP_AT, 32'sd0, 3'd0);
        send_cmd(OP_PEEK, 32'sd0, 3'd0);
        send_cmd(OP_FIND, 32'sh8000_0000, 3'd0);
        send_cmd(OP_FIND, 32'sh1234_5678, 3'd0);
        send_cmd(OP_FIND, 32'sd77, 3'd0);
        send_cmd(OP_POP, 32'sd0, 3'd0);
        send_cmd(OP_POP, 32'sd0, 3'd0);
    endtask

    // random mix of all operations, pushes slightly favored
    task automatic run_random_mix(input int count);
        int roll;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 38)
                send_cmd(OP_PUSH, pick_word(), 3'($urandom_range(7)));
            else if (roll < 62)
                send_cmd(OP_POP, pick_word(), 3'($urandom_range(7)));
            else if (roll < 70)
                send_cmd(OP_PEEK, pick_word(), 3'($urandom_range(7)));
            else if (roll < 82)
                send_cmd(OP_AT, pick_word(), pick_index());
            else if (roll < 95)
                send_cmd(OP_FIND, pick_search_word(), 3'($urandom_range(7)));
            else
                send_cmd(OP_FIND + 3'($urandom_range(3, 1)), pick_word(),
                         3'($urandom_range(7)));
        end
    endtask

    // back to back fill and drain sequences, with searches and reads in between
    task automatic run_fill_drain_rounds(input int rounds);
        int target;
        sender_idles = 1'b0;
        repeat (rounds) begin
            target = $urandom_range(DEPTH, 1);
            while (fifo_count < target)
                send_cmd(OP_PUSH, pick_word(), 3'($urandom_range(7)));
            if (fifo_count == DEPTH)
                send_cmd(OP_PUSH, pick_word(), 3'($urandom_range(7)));
            repeat (3) send_cmd(OP_FIND, pick_search_word(), 3'($urandom_range(7)));
            repeat (2) send_cmd(OP_AT, pick_word(), pick_index());
            while (fifo_count > 0)
                send_cmd(OP_POP, pick_word(), 3'($urandom_range(7)));
            send_cmd(OP_POP, pick_word(), 3'($urandom_range(7)));
        end
        sender_idles = 1'b1;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_responses.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p",
                         $time, o_result);
                error_count++;
            end else begin
                want = pending_responses.pop_front();
                check_field("status", 32'(want.status), 32'(o_result.status));
                check_field("read_value", want.read_value, o_result.read_value);
                check_field("found_index", 32'(want.found_index),
                            32'(o_result.found_index));
                check_field("fill_level", 32'(want.fill_level), 32'(o_result.fill_level));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (i_start && !o_busy)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // test sequence
    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cmd   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed_corners();
        wait_until_drained();
        run_random_mix(620);
        wait_until_drained();
        run_fill_drain_rounds(18);
        wait_until_drained();
        run_random_mix(380);
        wait_until_drained();
        repeat (DEPTH + 4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

>>> files.f
hw/rtl/srf_pkg.sv
hw/rtl/srf_cell.sv
hw/rtl/srf_ctrl.sv
hw/rtl/searchable_ring_fifo.sv
hw/rtl/srf_checker.sv
bench/testbench.sv
